@@ design/bth_pkg.sv @@
package bth_pkg;

  // working width for byte offsets and tag sums
  localparam int ADDR_W = 36;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t OFF4  = addr_t'(4);
  localparam addr_t OFF8  = addr_t'(8);
  localparam addr_t OFF12 = addr_t'(12);
  localparam addr_t OFF15 = addr_t'(15);
  localparam addr_t OFF16 = addr_t'(16);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_ALLOC = 2'd0;
  localparam logic [1:0] STAT_FREED = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;
  localparam logic [1:0] STAT_OOM   = 2'd3;

  localparam logic [31:0] TAG_PROLOGUE = 32'd9;
  localparam logic [31:0] TAG_EPILOGUE = 32'd1;

endpackage

@@ design/bth_cmd_if.sv @@
interface bth_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] request_size;
  logic [15:0] block_address;

  modport source (output valid, output command, output request_size,
                  output block_address, input ready);
  modport sink (input valid, input command, input request_size,
                input block_address, output ready);
endinterface

@@ design/bth_rsp_if.sv @@
interface bth_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic [1:0]  status;

  modport source (output valid, output result_address, output status, input ready);
  modport sink (input valid, input result_address, input status, output ready);
endinterface

@@ design/boundary_tag_heap_allocator.sv @@
// an allocate walks the blocks from the rover, and grows the heap and merges
// when no free block fits; a free clears the tags of its block and merges
// one command at a time: every memory read goes through the one registered read port of the heap ram
// reset: a clearing pass over all HEAP_WORDS words, then the prologue, first free
// chunk and epilogue are laid down; cmd.ready stays low until then
module boundary_tag_heap_allocator #(
  parameter int HEAP_WORDS  = 16384,
  parameter int CHUNK_BYTES = 4096
) (
  input logic clk,
  input logic rst,
  bth_cmd_if.sink cmd,
  bth_rsp_if.source rsp
);

  localparam int IW = $clog2(HEAP_WORDS);
  localparam bth_pkg::addr_t HEAP_BYTES = bth_pkg::addr_t'(HEAP_WORDS) << 2;
  localparam int CHUNK_W = CHUNK_BYTES / 4;
  localparam bth_pkg::addr_t CHUNK_ROUND = bth_pkg::addr_t'((CHUNK_W + CHUNK_W % 2) * 4);
  localparam bth_pkg::addr_t CHUNK_RAW = bth_pkg::addr_t'(CHUNK_BYTES);

  localparam logic [5:0] S_CLR = 6'd0,  S_I1 = 6'd1,  S_I2 = 6'd2,  S_I3 = 6'd3;
  localparam logic [5:0] S_IDLE = 6'd4, S_WALK0 = 6'd5, S_WALK1 = 6'd6;
  localparam logic [5:0] S_GROW0 = 6'd7, S_GW1 = 6'd8, S_GW2 = 6'd9, S_GW3 = 6'd10;
  localparam logic [5:0] S_M0 = 6'd11, S_M1 = 6'd12, S_M2 = 6'd13, S_M3 = 6'd14;
  localparam logic [5:0] S_M4 = 6'd15, S_M5 = 6'd16;
  localparam logic [5:0] S_MA1 = 6'd17, S_MA2 = 6'd18, S_MA3 = 6'd19;
  localparam logic [5:0] S_MB1 = 6'd20, S_MB2 = 6'd21, S_MB3 = 6'd22;
  localparam logic [5:0] S_MC1 = 6'd23, S_MC2 = 6'd24, S_MC3 = 6'd25, S_MC4 = 6'd26;
  localparam logic [5:0] S_MC5 = 6'd27, S_MC6 = 6'd28, S_MEND = 6'd29;
  localparam logic [5:0] S_P0 = 6'd30, S_P1 = 6'd31;
  localparam logic [5:0] S_PS1 = 6'd32, S_PS2 = 6'd33, S_PS3 = 6'd34, S_PS4 = 6'd35;
  localparam logic [5:0] S_PS5 = 6'd36, S_PS6 = 6'd37, S_PS7 = 6'd38;
  localparam logic [5:0] S_PN1 = 6'd39, S_PN2 = 6'd40, S_PN3 = 6'd41, S_PN4 = 6'd42;
  localparam logic [5:0] S_PN5 = 6'd43;
  localparam logic [5:0] S_F0 = 6'd44, S_F1 = 6'd45, S_F2 = 6'd46, S_F3 = 6'd47;
  localparam logic [5:0] S_DONE = 6'd48;

  localparam logic [1:0] MODE_INIT = 2'd0, MODE_ALLOC = 2'd1, MODE_FREE = 2'd2;

  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] mem_q;
  logic        rd_in_q;

  logic [5:0]  state;
  logic [1:0]  mode;
  logic [IW-1:0] clr_idx;
  bth_pkg::addr_t bp, pb, nb, s, s0, psz, c, asize, gsize, brk, rover;
  logic        pu;
  logic [15:0] pres;
  logic [1:0]  pstat;
  logic        ov;
  logic [15:0] ores;
  logic [1:0]  ostat;

  logic [31:0] rdata;
  bth_pkg::addr_t sz;
  bth_pkg::addr_t rd_addr, wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;
  logic        rd_in, wr_in;
  bth_pkg::addr_t req_ext, asize_in, s3;
  logic        addr_ok, cmd_acc;

  assign rdata = rd_in_q ? mem_q : 32'd0;
  assign sz    = bth_pkg::addr_t'({rdata[31:3], 3'b000});
  assign rd_in = (rd_addr >> 2) < bth_pkg::addr_t'(HEAP_WORDS);
  assign wr_in = (wr_addr >> 2) < bth_pkg::addr_t'(HEAP_WORDS);

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && (state == S_IDLE);
  assign rsp.valid = ov;
  assign rsp.result_address = ores;
  assign rsp.status = ostat;

  assign req_ext  = bth_pkg::addr_t'(cmd.request_size);
  assign asize_in = (req_ext <= bth_pkg::OFF8) ? bth_pkg::OFF16
                  : ((req_ext + bth_pkg::OFF15) & ~bth_pkg::addr_t'(7));
  assign addr_ok  = (cmd.block_address[2:0] == 3'd0)
                  && (bth_pkg::addr_t'(cmd.block_address) >= bth_pkg::OFF16)
                  && (bth_pkg::addr_t'(cmd.block_address) < brk);
  assign s3 = s0 + psz + sz;

  // heap ram, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en && wr_in) mem[wr_addr[IW+1:2]] <= wr_data;
    mem_q   <= mem[rd_addr[IW+1:2]];
    rd_in_q <= rd_in;
  end

  always_comb begin
    rd_addr = bp - bth_pkg::OFF4;
    wr_addr = bp - bth_pkg::OFF4;
    wr_en   = 1'b0;
    wr_data = s[31:0];
    case (state)
      S_CLR: begin
        wr_en = 1'b1;
        wr_addr = bth_pkg::addr_t'(clr_idx) << 2;
        wr_data = 32'd0;
      end
      S_I1: begin
        wr_en = 1'b1; wr_addr = bth_pkg::OFF4; wr_data = bth_pkg::TAG_PROLOGUE;
      end
      S_I2: begin
        wr_en = 1'b1; wr_addr = bth_pkg::OFF8; wr_data = bth_pkg::TAG_PROLOGUE;
      end
      S_I3: begin
        wr_en = 1'b1; wr_addr = bth_pkg::OFF12; wr_data = bth_pkg::TAG_EPILOGUE;
      end
      S_WALK1: rd_addr = bp + sz - bth_pkg::OFF4;
      S_GW1: begin
        wr_en = 1'b1; wr_data = gsize[31:0];
      end
      S_GW2: begin
        wr_en = 1'b1; wr_addr = bp + gsize - bth_pkg::OFF8; wr_data = gsize[31:0];
      end
      S_GW3: begin
        wr_en = 1'b1; wr_addr = bp + gsize - bth_pkg::OFF4;
        wr_data = bth_pkg::TAG_EPILOGUE;
      end
      S_M0, S_MB2, S_MC5: rd_addr = bp - bth_pkg::OFF8;
      S_M1: rd_addr = bp - sz - bth_pkg::OFF4;
      S_M2: rd_addr = pb + sz - bth_pkg::OFF8;
      S_M4, S_MC3: rd_addr = bp + sz - bth_pkg::OFF4;
      S_MA1, S_F3: begin
        wr_en = 1'b1;
        if (state == S_F3) wr_addr = bp + sz - bth_pkg::OFF8;
      end
      S_MA3: begin
        wr_en = 1'b1; wr_addr = bp + sz - bth_pkg::OFF8;
      end
      S_MB1: begin
        wr_en = 1'b1; wr_addr = bp + s0 - bth_pkg::OFF8;
      end
      S_MB3: begin
        wr_en = 1'b1; wr_addr = bp - sz - bth_pkg::OFF4;
      end
      S_MC1: begin
        wr_en = 1'b1; wr_addr = pb - bth_pkg::OFF4;
      end
      S_MC4: begin
        wr_en = 1'b1; wr_addr = nb + sz - bth_pkg::OFF8;
      end
      S_PS1: begin
        wr_en = 1'b1; wr_data = asize[31:0] | 32'd1;
      end
      S_PS3: begin
        wr_en = 1'b1; wr_addr = bp + sz - bth_pkg::OFF8; wr_data = asize[31:0] | 32'd1;
      end
      S_PS5: begin
        wr_en = 1'b1; wr_addr = bp + sz - bth_pkg::OFF4;
        wr_data = 32'(c - asize);
      end
      S_PS6: rd_addr = nb - bth_pkg::OFF4;
      S_PS7: begin
        wr_en = 1'b1; wr_addr = nb + sz - bth_pkg::OFF8;
        wr_data = 32'(c - asize);
      end
      S_PN1: begin
        wr_en = 1'b1; wr_data = c[31:0] | 32'd1;
      end
      S_PN3: begin
        wr_en = 1'b1; wr_addr = bp + sz - bth_pkg::OFF8; wr_data = c[31:0] | 32'd1;
      end
      S_F1: begin
        wr_en = 1'b1; wr_data = sz[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      ov      <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) ov <= 1'b0;
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(HEAP_WORDS - 1)) state <= S_I1;
        end
        S_I1: state <= S_I2;
        S_I2: state <= S_I3;
        S_I3: begin
          brk   <= bth_pkg::OFF16;
          rover <= bth_pkg::OFF16;
          gsize <= CHUNK_ROUND;
          mode  <= MODE_INIT;
          state <= S_GROW0;
        end
        S_IDLE: begin
          if (cmd_acc) begin
            pres <= 16'd0;
            if (cmd.command == bth_pkg::CMD_FREE) begin
              pstat <= bth_pkg::STAT_FREED;
              bp    <= bth_pkg::addr_t'(cmd.block_address);
              mode  <= MODE_FREE;
              state <= addr_ok ? S_F0 : S_DONE;
            end else if (cmd.request_size == 16'd0) begin
              pstat <= bth_pkg::STAT_ZERO;
              state <= S_DONE;
            end else begin
              asize <= asize_in;
              bp    <= rover;
              mode  <= MODE_ALLOC;
              state <= S_WALK0;
            end
          end
        end
        S_WALK0: state <= S_WALK1;
        S_WALK1: begin
          if (sz == '0) begin
            gsize <= (asize > CHUNK_RAW) ? asize : CHUNK_ROUND;
            state <= S_GROW0;
          end else if (!rdata[0] && asize <= sz) begin
            state <= S_P0;
          end else begin
            bp <= bp + sz;
          end
        end
        S_GROW0: begin
          if (brk + gsize > HEAP_BYTES) begin
            pstat <= bth_pkg::STAT_OOM;
            state <= (mode == MODE_INIT) ? S_IDLE : S_DONE;
          end else begin
            bp    <= brk;
            brk   <= brk + gsize;
            state <= S_GW1;
          end
        end
        S_GW1: state <= S_GW2;
        S_GW2: state <= S_GW3;
        S_GW3: state <= S_M0;
        // merge: previous footer, previous header, its footer, own header, next header
        S_M0: state <= S_M1;
        S_M1: begin
          pb <= bp - sz;
          state <= S_M2;
        end
        S_M2: begin
          psz <= sz;
          state <= S_M3;
        end
        S_M3: begin
          pu <= rdata[0];
          state <= S_M4;
        end
        S_M4: begin
          s0 <= sz;
          state <= S_M5;
        end
        S_M5: begin
          if (pu && rdata[0]) begin
            state <= S_MEND;
          end else if (pu) begin
            s <= s0 + sz;
            state <= S_MA1;
          end else if (rdata[0]) begin
            s <= s0 + psz;
            state <= S_MB1;
          end else begin
            s <= s3;
            state <= S_MC1;
          end
        end
        S_MA1: state <= S_MA2;
        S_MA2: state <= S_MA3;
        S_MA3: state <= S_MEND;
        S_MB1: state <= S_MB2;
        S_MB2: state <= S_MB3;
        S_MB3: begin
          bp <= bp - sz;
          state <= S_MEND;
        end
        S_MC1: state <= S_MC2;
        S_MC2: state <= S_MC3;
        S_MC3: begin
          nb <= bp + sz;
          state <= S_MC4;
        end
        S_MC4: state <= S_MC5;
        S_MC5: state <= S_MC6;
        S_MC6: begin
          bp <= bp - sz;
          state <= S_MEND;
        end
        S_MEND: begin
          rover <= bp;
          case (mode)
            MODE_INIT:  state <= S_IDLE;
            MODE_FREE:  state <= S_DONE;
            default:    state <= S_P0;
          endcase
        end
        S_P0: state <= S_P1;
        S_P1: begin
          c <= sz;
          state <= (sz >= asize && sz - asize >= bth_pkg::OFF16) ? S_PS1 : S_PN1;
        end
        S_PS1: state <= S_PS2;
        S_PS2: state <= S_PS3;
        S_PS3: state <= S_PS4;
        S_PS4: state <= S_PS5;
        S_PS5: begin
          nb <= bp + sz;
          state <= S_PS6;
        end
        S_PS6: state <= S_PS7;
        S_PS7: begin
          rover <= nb;
          pres  <= bp[15:0];
          pstat <= bth_pkg::STAT_ALLOC;
          state <= S_DONE;
        end
        S_PN1: state <= S_PN2;
        S_PN2: state <= S_PN3;
        S_PN3: state <= S_PN4;
        S_PN4: state <= S_PN5;
        S_PN5: begin
          rover <= bp + sz;
          pres  <= bp[15:0];
          pstat <= bth_pkg::STAT_ALLOC;
          state <= S_DONE;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          s <= sz;
          state <= S_F2;
        end
        S_F2: state <= S_F3;
        S_F3: state <= S_M0;
        S_DONE: begin
          // hold until the output register is free
          if (!ov || rsp.ready) begin
            ov    <= 1'b1;
            ores  <= pres;
            ostat <= pstat;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ verif/bth_heap_checker.sv @@
module bth_heap_checker #(
  parameter int HEAP_WORDS  = 16384,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic clk,
  input  logic rst,
  bth_cmd_if   cmd,
  bth_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding,
  output int   alloc_ok_count,
  output int   free_count,
  output int   oom_count,
  output int   zero_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned off_t;
  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
  } heap_reply_t;

  logic [31:0] heap_mem [HEAP_WORDS];
  off_t        brk;
  off_t        rover;
  heap_reply_t replies_due [$];

  function automatic logic [31:0] rd(off_t a);
    off_t idx;
    idx = a >> 2;
    return (idx < off_t'(HEAP_WORDS)) ? heap_mem[idx] : 32'd0;
  endfunction

  function automatic void wr(off_t a, off_t v);
    off_t idx;
    idx = a >> 2;
    if (idx < off_t'(HEAP_WORDS)) heap_mem[idx] = v[31:0];
  endfunction

  function automatic off_t tag_sz(off_t a);
    return off_t'(rd(a) & ~32'd7);
  endfunction

  function automatic bit tag_busy(off_t a);
    logic [31:0] w;
    w = rd(a);
    return w[0];
  endfunction

  function automatic off_t nxt(off_t bp);
    return bp + tag_sz(bp - 4);
  endfunction

  function automatic off_t prv(off_t bp);
    return bp - tag_sz(bp - 8);
  endfunction

  function automatic off_t ftr(off_t bp);
    return bp + tag_sz(bp - 4) - 8;
  endfunction

  function automatic off_t coalesce(off_t bp);
    bit   pu;
    bit   nu;
    off_t s;
    pu = tag_busy(ftr(prv(bp)));
    nu = tag_busy(nxt(bp) - 4);
    s  = tag_sz(bp - 4);
    if (pu && !nu) begin
      s += tag_sz(nxt(bp) - 4);
      wr(bp - 4, s);
      wr(ftr(bp), s);
    end else if (!pu && nu) begin
      s += tag_sz(prv(bp) - 4);
      wr(ftr(bp), s);
      wr(prv(bp) - 4, s);
      bp = prv(bp);
    end else if (!pu && !nu) begin
      s += tag_sz(prv(bp) - 4) + tag_sz(nxt(bp) - 4);
      wr(prv(bp) - 4, s);
      wr(ftr(nxt(bp)), s);
      bp = prv(bp);
    end
    rover = bp;
    return bp;
  endfunction

  function automatic bit grow_heap(off_t bytes, output off_t bp);
    off_t words;
    off_t sz;
    words = bytes / 4;
    if (words[0]) words++;
    sz = words * 4;
    bp = 0;
    if (brk + sz > off_t'(HEAP_WORDS) * 4) return 0;
    bp = brk;
    brk += sz;
    wr(bp - 4, sz);
    wr(bp + sz - 8, sz);
    wr(bp + sz - 4, 1);
    bp = coalesce(bp);
    return 1;
  endfunction

  function automatic void carve(off_t bp, off_t asize);
    off_t c;
    c = tag_sz(bp - 4);
    if (c >= asize && c - asize >= 16) begin
      wr(bp - 4, asize | 1);
      wr(ftr(bp), asize | 1);
      bp = nxt(bp);
      wr(bp - 4, c - asize);
      wr(ftr(bp), c - asize);
      rover = bp;
    end else begin
      wr(bp - 4, c | 1);
      wr(ftr(bp), c | 1);
      rover = nxt(bp);
    end
  endfunction

  function automatic void heap_init();
    off_t bp;
    foreach (heap_mem[i]) heap_mem[i] = '0;
    wr(4, off_t'(bth_pkg::TAG_PROLOGUE));
    wr(8, off_t'(bth_pkg::TAG_PROLOGUE));
    wr(12, off_t'(bth_pkg::TAG_EPILOGUE));
    brk   = 16;
    rover = 16;
    void'(grow_heap(off_t'(CHUNK_BYTES), bp));
  endfunction

  function automatic heap_reply_t heap_apply(logic op, logic [15:0] req, logic [15:0] addr);
    heap_reply_t r;
    off_t        asize;
    off_t        bp;
    off_t        s;
    off_t        ext;
    bit          found;
    r = '0;
    if (op == bth_pkg::CMD_FREE) begin
      r.status = bth_pkg::STAT_FREED;
      if (addr[2:0] == 3'd0 && addr >= 16 && off_t'(addr) < brk) begin
        s = tag_sz(off_t'(addr) - 4);
        wr(off_t'(addr) - 4, s);
        wr(ftr(off_t'(addr)), s);
        bp = coalesce(off_t'(addr));
      end
    end else if (req == 16'd0) begin
      r.status = bth_pkg::STAT_ZERO;
    end else begin
      asize = (req <= 8) ? 16 : 8 * ((off_t'(req) + 15) / 8);
      found = 0;
      for (bp = rover; tag_sz(bp - 4) > 0; bp = nxt(bp)) begin
        if (!tag_busy(bp - 4) && asize <= tag_sz(bp - 4)) begin
          found = 1;
          break;
        end
      end
      if (!found) begin
        ext = (asize > off_t'(CHUNK_BYTES)) ? asize : off_t'(CHUNK_BYTES);
        found = grow_heap(ext, bp);
      end
      if (found) begin
        carve(bp, asize);
        r.result_address = bp[15:0];
        r.status = bth_pkg::STAT_ALLOC;
      end else begin
        r.status = bth_pkg::STAT_OOM;
      end
    end
    return r;
  endfunction

  initial heap_init();

  assign outstanding = replies_due.size();

  always @(posedge clk) begin
    heap_reply_t want;
    if (rst) begin
      heap_init();
      replies_due.delete();
      fail_count <= 0;
      alloc_ok_count <= 0;
      free_count <= 0;
      oom_count <= 0;
      zero_count <= 0;
    end else begin
      if (cmd.valid && cmd.ready)
        replies_due.push_back(heap_apply(cmd.command, cmd.request_size, cmd.block_address));
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply addr=%0d status=%0d", $time,
                   rsp.result_address, rsp.status);
          fail_count <= fail_count + 1;
        end else begin
          want = replies_due.pop_front();
          if (want.result_address !== rsp.result_address || want.status !== rsp.status) begin
            $display("%0t: reply mismatch expected addr=%0d status=%0d, got addr=%0d status=%0d",
                     $time, want.result_address, want.status,
                     rsp.result_address, rsp.status);
            fail_count <= fail_count + 1;
          end
          case (want.status)
            bth_pkg::STAT_ALLOC: alloc_ok_count <= alloc_ok_count + 1;
            bth_pkg::STAT_FREED: free_count <= free_count + 1;
            bth_pkg::STAT_OOM:   oom_count <= oom_count + 1;
            default:             zero_count <= zero_count + 1;
          endcase
        end
      end
    end
  end
endmodule

@@ verif/boundary_tag_heap_allocator_tb.sv @@
module boundary_tag_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, outstanding, alloc_ok_count, free_count, oom_count, zero_count;
  int   replies_seen = 0;
  int   idle_cycles = 0;
  logic [15:0] live_blocks [$];

  bth_cmd_if cmd ();
  bth_rsp_if rsp ();

  always #6 clk = ~clk;

  boundary_tag_heap_allocator uut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  bth_heap_checker chk (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
    .fail_count(fail_count), .outstanding(outstanding),
    .alloc_ok_count(alloc_ok_count), .free_count(free_count),
    .oom_count(oom_count), .zero_count(zero_count)
  );

  initial begin
    cmd.valid = 1'b0;
    cmd.command = bth_pkg::CMD_ALLOC;
    cmd.request_size = '0;
    cmd.block_address = '0;
    rsp.ready = 1'b0;
  end

  // track live blocks from granted allocations
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      replies_seen <= replies_seen + 1;
      if (rsp.status == bth_pkg::STAT_ALLOC) live_blocks.push_back(rsp.result_address);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: runs of full readiness, random stalls, one long hold-off
  initial begin
    int  run_len;
    bit  held = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && replies_seen >= 300) begin
        held = 1;
        rsp.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      run_len = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0: begin
          rsp.ready <= 1'b1;
          repeat (run_len) @(posedge clk);
        end
        1: repeat (run_len) begin
          rsp.ready <= ($urandom_range(0, 3) != 0);
          @(posedge clk);
        end
        default: begin
          rsp.ready <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      endcase
    end
  end

  int burst_left = 0;

  task automatic send_beat(logic op, logic [15:0] req, logic [15:0] addr);
    if (burst_left == 0) begin
      if (cmd.valid) cmd.valid <= 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    cmd.valid <= 1'b1;
    cmd.command <= op;
    cmd.request_size <= req;
    cmd.block_address <= addr;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic drain();
    if (cmd.valid) cmd.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // let the live block list catch up with the last reply
    @(posedge clk);
  endtask

  task automatic free_live(int idx);
    logic [15:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_beat(bth_pkg::CMD_FREE, 16'($urandom), a);
  endtask

  function automatic logic [15:0] alloc_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) return 16'd0;
    if (pick < 8) return 16'($urandom_range(1, 8));
    if (pick < 70) return 16'($urandom_range(9, 64));
    if (pick < 93) return 16'($urandom_range(65, 1024));
    if (pick < 97) return 16'($urandom_range(1025, 8192));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] bad_address();
    logic [15:0] a;
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 15));
    a = 16'($urandom);
    if (a[2:0] == 3'd0) a[2:0] = 3'($urandom_range(1, 7));
    return a;
  endfunction

  logic [15:0] five [5];
  int pick;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: size extremes, rounding edges, growth, out of memory and bad frees
    send_beat(bth_pkg::CMD_ALLOC, 16'd0, 16'hffff);
    send_beat(bth_pkg::CMD_ALLOC, 16'd1, 16'h0000);
    send_beat(bth_pkg::CMD_ALLOC, 16'd8, 16'h0);
    send_beat(bth_pkg::CMD_ALLOC, 16'd9, 16'h0);
    send_beat(bth_pkg::CMD_ALLOC, 16'd4096, 16'h0);
    send_beat(bth_pkg::CMD_ALLOC, 16'hffff, 16'h0);
    send_beat(bth_pkg::CMD_FREE, 16'hffff, 16'd0);
    send_beat(bth_pkg::CMD_FREE, 16'h0, 16'd13);
    send_beat(bth_pkg::CMD_FREE, 16'h0, 16'hffff);
    send_beat(bth_pkg::CMD_FREE, 16'h0, 16'd8);
    drain();
    for (int i = 0; i < 5; i++) send_beat(bth_pkg::CMD_ALLOC, 16'd24, 16'h0);
    drain();
    for (int i = 0; i < 5; i++) five[i] = live_blocks[live_blocks.size() - 5 + i];
    repeat (5) live_blocks.pop_back();
    // isolated, isolated, both neighbours free, next free, both neighbours free
    send_beat(bth_pkg::CMD_FREE, 16'h0, five[1]);
    send_beat(bth_pkg::CMD_FREE, 16'h0, five[3]);
    send_beat(bth_pkg::CMD_FREE, 16'h0, five[2]);
    send_beat(bth_pkg::CMD_FREE, 16'h0, five[0]);
    send_beat(bth_pkg::CMD_FREE, 16'h0, five[4]);
    send_beat(bth_pkg::CMD_ALLOC, 16'd40000, 16'h0);
    send_beat(bth_pkg::CMD_ALLOC, 16'd30000, 16'h0);
    drain();

    // random mix of allocations and frees of live blocks, plus ignored frees
    for (int n = 0; n < 930; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        send_beat(bth_pkg::CMD_FREE, 16'($urandom), bad_address());
      else if (pick < 50 && live_blocks.size() != 0)
        free_live($urandom_range(0, live_blocks.size() - 1));
      else
        send_beat(bth_pkg::CMD_ALLOC, alloc_size(), 16'($urandom));
    end
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d granted allocations, %0d frees, %0d out-of-memory, %0d zero-size",
             alloc_ok_count, free_count, oom_count, zero_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
